// ===== hw/rtl/mactp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mactp_pkg: shared types and constants of the mac address text parser
// character and result payloads, status codes and position constants
// ----------------------------------------------------------------------------
package mactp_pkg;

    localparam int unsigned CHAR_W = 8;
    localparam int unsigned ADDR_W = 48;
    localparam int unsigned NIB_W  = 4;
    localparam int unsigned POS_W  = 5;

    // string lengths and position limit
    localparam logic [POS_W-1:0] SPLIT_LEN = POS_W'(17);
    localparam logic [POS_W-1:0] PLAIN_LEN = POS_W'(12);
    localparam logic [POS_W-1:0] POS_LIMIT = POS_W'(18);

    // position of the first separator, and of the ones that must match it
    localparam logic [POS_W-1:0] SEP_POS   = POS_W'(2);
    localparam int unsigned      JOINT_NUM = 4;
    localparam logic [POS_W-1:0] JOINT_POS [JOINT_NUM] = '{
        POS_W'(5), POS_W'(8), POS_W'(11), POS_W'(14)
    };

    localparam logic [CHAR_W-1:0] CHAR_COLON = 8'h3A;
    localparam logic [CHAR_W-1:0] CHAR_DASH  = 8'h2D;

    typedef enum logic [1:0] {
        STATUS_OK       = 2'd0,
        STATUS_BAD_CHAR = 2'd1,
        STATUS_BAD_LEN  = 2'd2
    } mactp_status_t;

    typedef struct packed {
        logic [CHAR_W-1:0] char_code;
        logic              last_char;
    } mactp_char_t;

    typedef struct packed {
        logic [ADDR_W-1:0] address;
        mactp_status_t     status;
    } mactp_result_t;

endpackage

// ===== hw/rtl/mactp_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mactp_if: stream channels of the mac address text parser
// valid/ready channels for characters in and parse results out
// ----------------------------------------------------------------------------
interface mactp_char_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_char;

    modport source (output valid, output char_code, output last_char, input ready);
    modport sink   (input valid, input char_code, input last_char, output ready);
endinterface

interface mactp_result_if;
    logic        valid;
    logic        ready;
    logic [47:0] address;
    logic [1:0]  status;

    modport source (output valid, output address, output status, input ready);
    modport sink   (input valid, input address, input status, output ready);
endinterface

// ===== hw/rtl/mactp_in_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mactp_in_reg: input register stage
// captures one character transfer per cycle while the stage ahead advances
// ----------------------------------------------------------------------------
module mactp_in_reg
    import mactp_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    mactp_char_if.sink   char_in,
    input  logic         advance,
    output logic         item_valid,
    output mactp_char_t  item
);

    logic        valid_reg;
    logic        valid_next;
    mactp_char_t item_reg;
    logic        take;

    assign char_in.ready = !valid_reg || advance;
    assign take          = char_in.valid && char_in.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (char_in.ready)
        begin
            valid_next = char_in.valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // payload, no reset
    always_ff @(posedge clk)
    begin
        if (take)
        begin
            item_reg.char_code <= char_in.char_code;
            item_reg.last_char <= char_in.last_char;
        end
    end

    assign item_valid = valid_reg;
    assign item       = item_reg;

endmodule

// ===== hw/rtl/mactp_scan.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mactp_scan: per-string parse state
// tracks position, nibbles and form checks; forms the result on the last char
// ----------------------------------------------------------------------------
module mactp_scan
    import mactp_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          fire,
    input  mactp_char_t   item,
    output logic          res_valid,
    output mactp_result_t res
);

    logic [POS_W-1:0]  pos_reg;
    logic [POS_W-1:0]  pos_next;
    logic [ADDR_W-1:0] acc_reg;
    logic [ADDR_W-1:0] acc_next;
    logic [CHAR_W-1:0] sep_reg;
    logic [CHAR_W-1:0] sep_next;
    logic              plain_ok_reg;
    logic              plain_ok_next;
    logic              split_ok_reg;
    logic              split_ok_next;

    logic [NIB_W-1:0]  nib;
    logic              is_hex;
    logic              at_joint;
    logic [POS_W-1:0]  pos_step;
    logic [ADDR_W-1:0] acc_step;
    logic [CHAR_W-1:0] sep_step;
    logic              plain_ok_step;
    logic              split_ok_step;
    mactp_status_t     status;

    // hex digit decode, upper and lower case
    always_comb
    begin
        nib    = '0;
        is_hex = 1'b0;
        if (item.char_code >= 8'h30 && item.char_code <= 8'h39)
        begin
            nib    = NIB_W'(item.char_code - 8'h30);
            is_hex = 1'b1;
        end
        else if (item.char_code >= 8'h41 && item.char_code <= 8'h46)
        begin
            nib    = NIB_W'(item.char_code - 8'h37);
            is_hex = 1'b1;
        end
        else if (item.char_code >= 8'h61 && item.char_code <= 8'h66)
        begin
            nib    = NIB_W'(item.char_code - 8'h57);
            is_hex = 1'b1;
        end
    end

    always_comb
    begin
        at_joint = 1'b0;
        for (int i = 0; i < JOINT_NUM; i++)
        begin
            if (pos_reg == JOINT_POS[i])
            begin
                at_joint = 1'b1;
            end
        end
    end

    always_comb
    begin
        acc_step      = is_hex ? {acc_reg[ADDR_W-NIB_W-1:0], nib} : acc_reg;
        plain_ok_step = plain_ok_reg && !((pos_reg < PLAIN_LEN) && !is_hex);
        sep_step      = sep_reg;
        split_ok_step = split_ok_reg;
        if (pos_reg < SPLIT_LEN)
        begin
            if (pos_reg == SEP_POS)
            begin
                sep_step = item.char_code;
                if (item.char_code != CHAR_COLON && item.char_code != CHAR_DASH)
                begin
                    split_ok_step = 1'b0;
                end
            end
            else if (at_joint)
            begin
                if (item.char_code != sep_reg)
                begin
                    split_ok_step = 1'b0;
                end
            end
            else if (!is_hex)
            begin
                split_ok_step = 1'b0;
            end
        end
        pos_step = (pos_reg == POS_LIMIT) ? pos_reg : pos_reg + POS_W'(1);

        // length decides first
        if (pos_step == SPLIT_LEN)
        begin
            status = split_ok_step ? STATUS_OK : STATUS_BAD_CHAR;
        end
        else if (pos_step == PLAIN_LEN)
        begin
            status = plain_ok_step ? STATUS_OK : STATUS_BAD_CHAR;
        end
        else
        begin
            status = STATUS_BAD_LEN;
        end

        res.status  = status;
        res.address = (status == STATUS_OK) ? acc_step : '0;
        res_valid   = fire && item.last_char;

        pos_next      = pos_reg;
        acc_next      = acc_reg;
        sep_next      = sep_reg;
        plain_ok_next = plain_ok_reg;
        split_ok_next = split_ok_reg;
        if (fire)
        begin
            if (item.last_char)
            begin
                pos_next      = '0;
                acc_next      = '0;
                sep_next      = '0;
                plain_ok_next = 1'b1;
                split_ok_next = 1'b1;
            end
            else
            begin
                pos_next      = pos_step;
                acc_next      = acc_step;
                sep_next      = sep_step;
                plain_ok_next = plain_ok_step;
                split_ok_next = split_ok_step;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg      <= '0;
            acc_reg      <= '0;
            sep_reg      <= '0;
            plain_ok_reg <= 1'b1;
            split_ok_reg <= 1'b1;
        end
        else
        begin
            pos_reg      <= pos_next;
            acc_reg      <= acc_next;
            sep_reg      <= sep_next;
            plain_ok_reg <= plain_ok_next;
            split_ok_reg <= split_ok_next;
        end
    end

    a_pos_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        pos_reg <= POS_LIMIT)
        else $error("position beyond limit");

    a_addr_zero_on_error: assert property (@(posedge clk) disable iff (!rst_n)
        res_valid && res.status != STATUS_OK |-> res.address == '0)
        else $error("address not cleared on error status");

    a_restart_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        fire && item.last_char |=> pos_reg == '0 && plain_ok_reg && split_ok_reg)
        else $error("state not restarted after last character");

endmodule

// ===== hw/rtl/mactp_out_reg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mactp_out_reg: result register stage
// holds one result until its transfer and tells the pipe when it may advance
// ----------------------------------------------------------------------------
module mactp_out_reg
    import mactp_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            res_valid,
    input  mactp_result_t   res,
    output logic            advance,
    mactp_result_if.source  result_out
);

    logic          valid_reg;
    logic          valid_next;
    mactp_result_t res_reg;

    assign advance = !valid_reg || result_out.ready;

    always_comb
    begin
        valid_next = valid_reg;
        if (advance)
        begin
            valid_next = res_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && res_valid)
        begin
            res_reg <= res;
        end
    end

    assign result_out.valid   = valid_reg;
    assign result_out.address = res_reg.address;
    assign result_out.status  = res_reg.status;

endmodule

// ===== hw/rtl/mac_address_text_parser_unit.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// mac_address_text_parser_unit: streaming mac address text parser
// one ascii character per transfer in, one address and status per string out
// ----------------------------------------------------------------------------
// Characters of a MAC address string arrive one per transfer on char_in, the
// final one flagged by last_char. Accepted are 17 characters as six hex pairs
// joined by one separator (colon or dash, the same at every joint) and 12
// plain hex characters; hex may be upper or lower case. On the last character
// one result goes out on result_out: the 48-bit address (first octet in bits
// 47..40, zero unless status is ok) and status 0 ok, 1 bad character or
// separator, 2 wrong length. A wrong length wins over a bad character. The
// block takes one character per cycle while the result register can advance.
// The transfer of a last character lands in the input register, then the
// parse state update and status decision land in the result register, which
// offers the result. The result register frees itself in the same cycle its
// transfer completes, so the pipe stalls only while a result is held back.
// ----------------------------------------------------------------------------
module mac_address_text_parser_unit
    import mactp_pkg::*;
(
    input  logic            clk,
    input  logic            rst_n,
    mactp_char_if.sink      char_in,
    mactp_result_if.source  result_out
);

    logic          advance;
    logic          item_valid;
    mactp_char_t   item;
    logic          fire;
    logic          res_valid;
    mactp_result_t res;

    // input register, ready whenever the pipe can move
    mactp_in_reg u_in_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_in    (char_in),
        .advance    (advance),
        .item_valid (item_valid),
        .item       (item)
    );

    // a registered character is consumed when the result stage can advance
    assign fire = item_valid && advance;

    // parse state and status decision
    mactp_scan u_scan (
        .clk       (clk),
        .rst_n     (rst_n),
        .fire      (fire),
        .item      (item),
        .res_valid (res_valid),
        .res       (res)
    );

    // result register toward the sink
    mactp_out_reg u_out_reg (
        .clk        (clk),
        .rst_n      (rst_n),
        .res_valid  (res_valid),
        .res        (res),
        .advance    (advance),
        .result_out (result_out)
    );

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: mac address text parser unit
// a short table of directed strings, then random split, plain, broken and
// odd-length strings; every result transfer is checked against a hand-typed
// result or a character-level parse model kept in step with the accepted characters
// ----------------------------------------------------------------------------
module testbench;
    import mactp_pkg::*;

    // run shape
    localparam int RANDOM_CHARS = 1240;
    localparam int IDLE_PCT     = 29;
    localparam int CALM_FROM    = 500;      // no idling on either side between these
    localparam int CALM_TO      = 800;      // counts of accepted characters
    localparam int HOLD_AT      = 250;      // long result stall starts here
    localparam int HOLD_CYCLES  = 80;
    localparam int DRAIN_CYCLES = 8;        // margin after the last result
    localparam int CYCLE_LIMIT  = 100000;

    // one character transfer, with the result typed in by hand where the
    // string ends and its outcome is obvious
    typedef struct {
        mactp_char_t   ch;
        bit            typed;
        mactp_result_t want;
    } char_xfer_t;

    // one directed string; swap_pos puts a byte no string literal can hold
    typedef struct {
        string         text;
        int            swap_pos;
        logic [7:0]    swap_code;
        bit            closed;
        bit            typed;
        logic [47:0]   want_addr;
        mactp_status_t want_status;
    } text_row_t;

    localparam int ROW_NUM = 9;

    logic clk;
    logic rst_n;

    mactp_char_if   char_ch ();
    mactp_result_if res_ch ();

    mac_address_text_parser_unit DUT (
        .clk        (clk),
        .rst_n      (rst_n),
        .char_in    (char_ch),
        .result_out (res_ch)
    );

    text_row_t     text_rows [ROW_NUM];
    char_xfer_t    char_plan [$];        // characters still to be offered
    mactp_result_t pending_results [$];  // parse results owed by the block
    logic [7:0]    word [$];             // random string under construction

    // parse model state
    logic [4:0]  text_pos;
    logic [47:0] hex_shift;
    logic [7:0]  first_sep;
    bit          plain_ok;
    bit          split_ok;

    int  chars_taken;
    int  results_seen;
    int  fail_count;
    int  cycle_count;
    int  status_seen [3];
    bit  source_busy;

    // ------------------------------------------------------------------------
    // clock, reset, cycle limit
    // ------------------------------------------------------------------------
    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    initial
    begin
        rst_n = 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
    end

    initial
    begin : watchdog
        wait (cycle_count >= CYCLE_LIMIT);
        $display("%0t: cycle limit reached, %0d results still owed, %0d characters unsent",
                 $time, pending_results.size(), char_plan.size());
        $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // parse model
    // ------------------------------------------------------------------------
    function automatic void clear_parse();
        text_pos  = '0;
        hex_shift = '0;
        first_sep = '0;
        plain_ok  = 1'b1;
        split_ok  = 1'b1;
    endfunction

    // advance the model by one accepted character; the last one owes a result
    function automatic void parse_char(char_xfer_t x);
        logic [7:0]    c;
        logic [4:0]    nib;
        bit            is_hex;
        mactp_result_t res;
        c = x.ch.char_code;
        if (c >= "0" && c <= "9")
            nib = 5'(c - "0");
        else if (c >= "A" && c <= "F")
            nib = 5'(c - "A" + 10);
        else if (c >= "a" && c <= "f")
            nib = 5'(c - "a" + 10);
        else
            nib = 5'd16;
        is_hex = (nib < 5'd16);

        // separators never reach the shift register
        if (is_hex)
            hex_shift = {hex_shift[43:0], nib[3:0]};
        if (text_pos < PLAIN_LEN && !is_hex)
            plain_ok = 1'b0;
        if (text_pos < SPLIT_LEN)
        begin
            if (text_pos == SEP_POS)
            begin
                first_sep = c;
                if (c != CHAR_COLON && c != CHAR_DASH)
                    split_ok = 1'b0;
            end
            else if ((text_pos % 3) == 2)
            begin
                if (c != first_sep)
                    split_ok = 1'b0;
            end
            else if (!is_hex)
            begin
                split_ok = 1'b0;
            end
        end
        // position sticks one past the split length
        text_pos = (text_pos < POS_LIMIT) ? text_pos + 5'd1 : POS_LIMIT;

        if (x.ch.last_char)
        begin
            // length decides first, character faults only count at 12 or 17
            if (text_pos == SPLIT_LEN)
                res.status = split_ok ? STATUS_OK : STATUS_BAD_CHAR;
            else if (text_pos == PLAIN_LEN)
                res.status = plain_ok ? STATUS_OK : STATUS_BAD_CHAR;
            else
                res.status = STATUS_BAD_LEN;
            res.address = (res.status == STATUS_OK) ? hex_shift : '0;
            pending_results.push_back(x.typed ? x.want : res);
            clear_parse();
        end
    endfunction

    // compare one result transfer with the oldest owed result
    function automatic void check_result(logic [47:0] addr, logic [1:0] stat);
        mactp_result_t exp;
        results_seen++;
        if (pending_results.size() == 0)
        begin
            $display("%0t: unexpected result, address %h status %0d", $time, addr, stat);
            fail_count++;
            return;
        end
        exp = pending_results.pop_front();
        status_seen[exp.status]++;
        if (stat !== exp.status)
        begin
            $display("%0t: status mismatch, expected %0d actual %0d", $time, exp.status, stat);
            fail_count++;
        end
        if (addr !== exp.address)
        begin
            $display("%0t: address mismatch, expected %h actual %h", $time, exp.address, addr);
            fail_count++;
        end
    endfunction

    // ------------------------------------------------------------------------
    // stimulus helpers
    // ------------------------------------------------------------------------
    function automatic bit idle_roll();
        if (chars_taken >= CALM_FROM && chars_taken < CALM_TO)
            return 1'b0;
        return ($urandom_range(0, 99) < IDLE_PCT);
    endfunction

    // random hex digit, either case
    function automatic logic [7:0] hex_char();
        logic [3:0] v;
        v = 4'($urandom_range(0, 15));
        if (v < 4'd10)
            return "0" + 8'(v);
        return ($urandom_range(0, 1) ? "a" : "A") + 8'(v - 10);
    endfunction

    // well-formed string of either form, separator picked at random
    function automatic void fill_word(bit split_form);
        logic [7:0] sep;
        word.delete();
        sep = $urandom_range(0, 1) ? CHAR_COLON : CHAR_DASH;
        if (split_form)
            for (int i = 0; i < SPLIT_LEN; i++)
                word.push_back(((i % 3) == 2) ? sep : hex_char());
        else
            for (int i = 0; i < PLAIN_LEN; i++)
                word.push_back(hex_char());
    endfunction

    // ------------------------------------------------------------------------
    // stimulus plan: directed table, then random strings
    // ------------------------------------------------------------------------
    initial
    begin : stimulus
        char_xfer_t x;
        int         kind;
        int         len;
        int         planned;
        logic [7:0] code;

        clear_parse();
        chars_taken  = 0;
        results_seen = 0;
        fail_count   = 0;
        source_busy  = 1'b0;
        planned      = 0;
        foreach (status_seen[s])
            status_seen[s] = 0;
        x.ch    = '0;
        x.typed = 1'b0;
        x.want  = '0;

        text_rows = '{
            // plain form, mixed case
            '{"0123456789aB", -1, 8'h00, 1'b1, 1'b1, 48'h0123456789AB, STATUS_OK},
            // split form with colons, every letter in both cases
            '{"Ff:eE:dD:Cc:Bb:Aa", -1, 8'h00, 1'b1, 1'b1, 48'hFFEEDDCCBBAA, STATUS_OK},
            // string spread over two rows, the first without its last flag
            '{"aa-bb-cc", -1, 8'h00, 1'b0, 1'b0, 48'h0, STATUS_OK},
            '{"-dd-ee-ff", -1, 8'h00, 1'b1, 1'b1, 48'hAABBCCDDEEFF, STATUS_OK},
            // dash at one joint after a colon
            '{"01:23-45:67:89:ab", -1, 8'h00, 1'b1, 1'b1, 48'h0, STATUS_BAD_CHAR},
            // dot as the first separator
            '{"01.23.45.67.89.ab", -1, 8'h00, 1'b1, 1'b1, 48'h0, STATUS_BAD_CHAR},
            // zero byte inside a plain-length string
            '{"0123456789ab", 5, 8'h00, 1'b1, 1'b1, 48'h0, STATUS_BAD_CHAR},
            // single top code
            '{"?", 0, 8'hFF, 1'b1, 1'b1, 48'h0, STATUS_BAD_LEN},
            // long string of junk, past the position limit: length wins
            '{"zzzzzzzzzzzzzzzzzzzz", 0, 8'h00, 1'b1, 1'b0, 48'h0, STATUS_BAD_LEN}
        };

        foreach (text_rows[r])
        begin
            for (int i = 0; i < text_rows[r].text.len(); i++)
            begin
                x.ch.char_code = (i == text_rows[r].swap_pos) ? text_rows[r].swap_code
                                                              : text_rows[r].text[i];
                x.ch.last_char = text_rows[r].closed && (i == text_rows[r].text.len() - 1);
                x.typed        = x.ch.last_char && text_rows[r].typed;
                x.want.address = text_rows[r].want_addr;
                x.want.status  = text_rows[r].want_status;
                char_plan.push_back(x);
            end
        end

        // random part: mostly well-formed strings, with broken ones and noise mixed in
        x.typed = 1'b0;
        x.want  = '0;
        while (planned < RANDOM_CHARS)
        begin
            kind = $urandom_range(0, 99);
            if (kind < 65)
            begin
                fill_word(kind < 40);
            end
            else if (kind < 88)
            begin
                fill_word(kind < 78);
                if (kind < 72)
                begin
                    // swap one joint to the other separator
                    code = (word[2] == CHAR_COLON) ? CHAR_DASH : CHAR_COLON;
                    word[3 * $urandom_range(1, 4) + 2] = code;
                end
                else
                begin
                    repeat ($urandom_range(1, 2))
                        word[$urandom_range(0, word.size() - 1)] = 8'($urandom);
                end
            end
            else
            begin
                // odd lengths, often right around the two legal ones
                word.delete();
                len = $urandom_range(0, 1) ? $urandom_range(10, 19) : $urandom_range(1, 24);
                repeat (len)
                    word.push_back($urandom_range(0, 1) ? hex_char() : 8'($urandom));
            end
            foreach (word[i])
            begin
                x.ch.char_code = word[i];
                x.ch.last_char = (i == word.size() - 1);
                char_plan.push_back(x);
            end
            planned += word.size();
        end

        // drain: all characters sent, all results back, then the drain margin
        wait (rst_n === 1'b1);
        while (char_plan.size() > 0 || source_busy || pending_results.size() > 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        $display("covered %0d characters and %0d results: %0d ok, %0d bad character,",
                 chars_taken, results_seen, status_seen[STATUS_OK],
                 status_seen[STATUS_BAD_CHAR]);
        $display("%0d bad length, %0d mismatches, %0d results never delivered",
                 status_seen[STATUS_BAD_LEN], fail_count, pending_results.size());
        if (fail_count == 0 && pending_results.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    // ------------------------------------------------------------------------
    // character source: holds each character until its transfer, idles at
    // random between characters
    // ------------------------------------------------------------------------
    initial
    begin : char_source
        char_xfer_t cur;
        bit         holding;
        char_ch.valid     <= 1'b0;
        char_ch.char_code <= '0;
        char_ch.last_char <= 1'b0;
        holding   = 1'b0;
        cur.ch    = '0;
        cur.typed = 1'b0;
        cur.want  = '0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (char_ch.valid && char_ch.ready)
            begin
                parse_char(cur);
                chars_taken++;
                holding = 1'b0;
            end
            if (!holding && char_plan.size() > 0 && !idle_roll())
            begin
                cur     = char_plan.pop_front();
                holding = 1'b1;
            end
            source_busy = holding || (char_plan.size() > 0);
            // one assignment per signal per edge keeps valid steady across transfers
            char_ch.valid     <= holding;
            char_ch.char_code <= cur.ch.char_code;
            char_ch.last_char <= cur.ch.last_char;
        end
    end

    // ------------------------------------------------------------------------
    // result sink: random stalls plus one long hold-off that backs the pipe
    // up into the character side
    // ------------------------------------------------------------------------
    initial
    begin : result_sink
        int hold_left;
        bit hold_done;
        res_ch.ready <= 1'b0;
        hold_left = 0;
        hold_done = 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (res_ch.valid && res_ch.ready)
                check_result(res_ch.address, res_ch.status);
            if (!hold_done && chars_taken >= HOLD_AT)
            begin
                hold_left = HOLD_CYCLES;
                hold_done = 1'b1;
            end
            if (hold_left > 0)
            begin
                hold_left--;
                res_ch.ready <= 1'b0;
            end
            else
            begin
                res_ch.ready <= !idle_roll();
            end
        end
    end

endmodule

// ===== files.f =====
hw/rtl/mactp_pkg.sv
hw/rtl/mactp_if.sv
hw/rtl/mactp_in_reg.sv
hw/rtl/mactp_scan.sv
hw/rtl/mactp_out_reg.sv
hw/rtl/mac_address_text_parser_unit.sv
tb/testbench.sv
